[rtl/thfd_pkg.sv]
// Package for the temperature and humidity frame decoder.
// Holds the byte position codes, CRC-8 constants, conversion constants and the CRC function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package thfd_pkg;

   typedef logic [2:0] pos_type;

   localparam pos_type POS_TEMP_MSB = 3'd0;
   localparam pos_type POS_TEMP_LSB = 3'd1;
   localparam pos_type POS_TEMP_CRC = 3'd2;
   localparam pos_type POS_HUM_MSB  = 3'd3;
   localparam pos_type POS_HUM_LSB  = 3'd4;
   localparam pos_type POS_HUM_CRC  = 3'd5;
   localparam pos_type POS_IDLE     = 3'd6;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam int RAW_WIDTH  = 16;
   localparam int TEMP_WIDTH = 18;
   localparam int HUM_WIDTH  = 17;
   localparam int FRAC_BITS  = 13;

   localparam logic [14:0] TEMP_SCALE  = 15'd21875;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam logic [18:0] TEMP_OFFSET = 19'd45000;

   typedef logic signed [TEMP_WIDTH-1:0] temp_type;
   typedef logic [HUM_WIDTH-1:0]         hum_type;

   // One byte of CRC-8, most significant bit first, no final XOR.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      acc = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (acc[7]) begin
            acc = {acc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

[rtl/temp_humidity_frame_decoder.sv]
// Top level of the temperature and humidity frame decoder.
// Depends on thfd_pkg and thfd_convert.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one reply byte per transfer and accepts a byte in every cycle unless the
// input side stalls. Each byte passes an input register and is then checked and decoded; on
// the sixth byte of a frame the converted values and CRC flags land in the result register.
// The input side stalls only when a byte that closes a frame meets a result that has not yet
// been taken. A byte with the frame start flag always restarts the frame, and bytes outside
// a frame give no result.
module temp_humidity_frame_decoder
   import thfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output temp_type        rsp_temperature_milli,
   output hum_type         rsp_humidity_milli,
   output logic            rsp_temperature_crc_ok,
   output logic            rsp_humidity_crc_ok,
   output logic            rsp_frame_ok
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_data_ff;
   logic                 in_start_ff;

   pos_type              pos_ff, pos_in;
   logic [7:0]           crc_ff, crc_in;
   logic [RAW_WIDTH-1:0] temp_raw_ff, temp_raw_in;
   logic                 temp_ok_ff, temp_ok_in;
   logic [7:0]           hum_hi_ff, hum_hi_in;
   logic [7:0]           hum_lo_ff, hum_lo_in;

   logic                 out_valid_ff, out_valid_in;
   temp_type             out_temp_ff;
   hum_type              out_hum_ff;
   logic                 out_temp_ok_ff;
   logic                 out_hum_ok_ff;

   pos_type              eff_pos;
   logic [7:0]           eff_crc;
   logic [7:0]           crc_step;
   logic                 emits;
   logic                 out_free;
   logic                 stage_go;
   logic                 req_fire;
   logic                 rsp_fire;
   logic                 hum_ok;
   temp_type             conv_temp;
   hum_type              conv_hum;

   thfd_convert u_convert (
      .temperature_raw   (temp_raw_ff),
      .humidity_raw      ({hum_hi_ff, hum_lo_ff}),
      .temperature_milli (conv_temp),
      .humidity_milli    (conv_hum)
   );

   assign eff_pos  = in_start_ff ? POS_TEMP_MSB : pos_ff;
   assign eff_crc  = in_start_ff ? CRC_INIT : crc_ff;
   assign crc_step = crc8_update(eff_crc, in_data_ff);
   assign emits    = (eff_pos == POS_HUM_CRC);
   assign hum_ok   = (eff_crc == in_data_ff);

   assign rsp_fire  = out_valid_ff && rsp_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign stage_go  = in_valid_ff && (!emits || out_free);
   assign req_ready = !in_valid_ff || stage_go;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in = req_fire || (in_valid_ff && !stage_go);

   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      temp_raw_in = temp_raw_ff;
      temp_ok_in  = temp_ok_ff;
      hum_hi_in   = hum_hi_ff;
      hum_lo_in   = hum_lo_ff;
      if (stage_go) begin
         unique case (eff_pos)
            POS_TEMP_MSB: begin
               crc_in      = crc_step;
               temp_raw_in = {in_data_ff, temp_raw_ff[7:0]};
               pos_in      = POS_TEMP_LSB;
            end
            POS_TEMP_LSB: begin
               crc_in      = crc_step;
               temp_raw_in = {temp_raw_ff[15:8], in_data_ff};
               pos_in      = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               temp_ok_in = (eff_crc == in_data_ff);
               crc_in     = CRC_INIT;
               pos_in     = POS_HUM_MSB;
            end
            POS_HUM_MSB: begin
               crc_in    = crc_step;
               hum_hi_in = in_data_ff;
               pos_in    = POS_HUM_LSB;
            end
            POS_HUM_LSB: begin
               crc_in    = crc_step;
               hum_lo_in = in_data_ff;
               pos_in    = POS_HUM_CRC;
            end
            POS_HUM_CRC: begin
               crc_in = CRC_INIT;
               pos_in = POS_IDLE;
            end
            default: begin
               pos_in = pos_ff;
            end
         endcase
      end
   end

   assign out_valid_in = (stage_go && emits) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= POS_IDLE;
         crc_ff       <= CRC_INIT;
         temp_raw_ff  <= '0;
         temp_ok_ff   <= 1'b0;
         hum_hi_ff    <= '0;
         hum_lo_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         temp_raw_ff  <= temp_raw_in;
         temp_ok_ff   <= temp_ok_in;
         hum_hi_ff    <= hum_hi_in;
         hum_lo_ff    <= hum_lo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (stage_go && emits) begin
         out_temp_ff    <= conv_temp;
         out_hum_ff     <= conv_hum;
         out_temp_ok_ff <= temp_ok_ff;
         out_hum_ok_ff  <= hum_ok;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_temperature_milli  = out_temp_ff;
   assign rsp_humidity_milli     = out_hum_ff;
   assign rsp_temperature_crc_ok = out_temp_ok_ff;
   assign rsp_humidity_crc_ok    = out_hum_ok_ff;
   assign rsp_frame_ok           = out_temp_ok_ff && out_hum_ok_ff;

   // The byte position is idle, and no input byte or result is held, in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (pos_ff == POS_IDLE && !out_valid_ff && !in_valid_ff))
      else $error("decoder state not idle after reset");

   // A new result only comes from a byte that closes a frame.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (out_valid_in && !out_valid_ff) |-> (stage_go && emits))
      else $error("result raised without a closing byte");

   // A closing byte never overwrites a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (stage_go && emits) |-> out_free)
      else $error("pending result overwritten");

   // A held input byte keeps its register loaded.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !stage_go) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled input byte lost");

endmodule

`default_nettype wire

[rtl/thfd_convert.sv]
// Fixed-point conversion of the raw sensor words to milli-units.
// Depends on thfd_pkg for the scale factors and result types.
`timescale 1ns / 1ps
`default_nettype none

module thfd_convert
   import thfd_pkg::*;
(
   input  wire logic [RAW_WIDTH-1:0] temperature_raw,
   input  wire logic [RAW_WIDTH-1:0] humidity_raw,
   output temp_type                  temperature_milli,
   output hum_type                   humidity_milli
);

   logic [30:0] temp_product;
   logic [29:0] hum_product;
   logic [18:0] temp_scaled;
   logic [18:0] temp_shifted;

   assign temp_product = 31'(temperature_raw) * 31'(TEMP_SCALE);
   assign hum_product  = 30'(humidity_raw) * 30'(HUM_SCALE);

   assign temp_shifted      = {1'b0, temp_product[30:FRAC_BITS]};
   assign temp_scaled       = temp_shifted - TEMP_OFFSET;
   assign temperature_milli = temp_scaled[TEMP_WIDTH-1:0];
   assign humidity_milli    = hum_product[29:FRAC_BITS];

endmodule

`default_nettype wire

[test/tb_temp_humidity_frame_decoder.sv]
// Self-checking testbench for temp_humidity_frame_decoder: feeds sensor reply frames and
// compares every decoded reading against an in-bench frame decoder and CRC-8 checker.
// Depends on thfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_temp_humidity_frame_decoder;
   import thfd_pkg::*;

   localparam int          ITEMS_PER_PHASE = 420;
   localparam int          STALL_LIMIT     = 3000;
   localparam logic [7:0]  CRC8_SEED       = 8'hFF;
   localparam logic [7:0]  CRC8_POLY       = 8'h31;
   localparam int unsigned TEMP_GAIN       = 21875;
   localparam int unsigned TEMP_BIAS       = 45000;
   localparam int unsigned HUM_GAIN        = 12500;
   localparam int          SCALE_SHIFT     = 13;

   typedef struct {
      logic [7:0] data;
      logic       start;
   } reply_byte_type;

   typedef struct {
      temp_type temp_milli;
      hum_type  hum_milli;
      logic     temp_crc_ok;
      logic     hum_crc_ok;
      logic     frame_ok;
   } reading_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_frame_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   temp_type   rsp_temperature_milli;
   hum_type    rsp_humidity_milli;
   logic       rsp_temperature_crc_ok;
   logic       rsp_humidity_crc_ok;
   logic       rsp_frame_ok;

   reply_byte_type reply_bytes[$];
   reading_type    pending_readings[$];
   logic           req_taken = 1'b0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;

   pos_type     frame_pos;
   logic [7:0]  crc_acc;
   logic [15:0] temp_word;
   logic        temp_pass;
   logic [7:0]  hum_hi;
   logic [7:0]  hum_lo;

   temp_humidity_frame_decoder u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_frame_start        (req_frame_start),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_temperature_milli  (rsp_temperature_milli),
      .rsp_humidity_milli     (rsp_humidity_milli),
      .rsp_temperature_crc_ok (rsp_temperature_crc_ok),
      .rsp_humidity_crc_ok    (rsp_humidity_crc_ok),
      .rsp_frame_ok           (rsp_frame_ok)
   );

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   function automatic logic [15:0] pick_raw_word();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 16'h0000;
      if (sel == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic s);
      reply_byte_type it;
      it.data = b;
      it.start = s;
      reply_bytes.push_back(it);
   endtask

   // Queues the first len bytes of a frame; a bad check byte is always a wrong CRC.
   task automatic queue_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input bit t_good, input bit h_good, input int len);
      logic [7:0] frame_bytes[6];
      logic [7:0] crc;
      frame_bytes[0] = t_raw[15:8];
      frame_bytes[1] = t_raw[7:0];
      crc = crc8_step(crc8_step(CRC8_SEED, t_raw[15:8]), t_raw[7:0]);
      frame_bytes[2] = t_good ? crc : crc ^ 8'($urandom_range(255, 1));
      frame_bytes[3] = h_raw[15:8];
      frame_bytes[4] = h_raw[7:0];
      crc = crc8_step(crc8_step(CRC8_SEED, h_raw[15:8]), h_raw[7:0]);
      frame_bytes[5] = h_good ? crc : crc ^ 8'($urandom_range(255, 1));
      for (int i = 0; i < len; i++) queue_byte(frame_bytes[i], i == 0);
   endtask

   task automatic queue_random_traffic(input int n_items);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            queue_frame(pick_raw_word(), pick_raw_word(), $urandom_range(3) != 0,
                        $urandom_range(3) != 0, 6);
            sent += 6;
         end else if (kind < 92) begin
            len = $urandom_range(5, 1);
            queue_frame(pick_raw_word(), pick_raw_word(), 1'b1, 1'b1, len);
            sent += len;
         end else begin
            len = $urandom_range(4, 1);
            repeat (len) queue_byte(8'($urandom), 1'b0);
            sent += len;
         end
      end
   endtask

   task automatic decode_reply_byte(input logic [7:0] b, input logic start);
      reading_type r;
      int unsigned scaled;
      if (start) begin
         frame_pos = POS_TEMP_MSB;
         crc_acc = CRC8_SEED;
      end
      if (frame_pos < POS_IDLE) begin
         case (frame_pos)
            POS_TEMP_MSB: begin
               crc_acc = crc8_step(crc_acc, b);
               temp_word[15:8] = b;
            end
            POS_TEMP_LSB: begin
               crc_acc = crc8_step(crc_acc, b);
               temp_word[7:0] = b;
            end
            POS_TEMP_CRC: begin
               temp_pass = (crc_acc == b);
               crc_acc = CRC8_SEED;
            end
            POS_HUM_MSB: begin
               crc_acc = crc8_step(crc_acc, b);
               hum_hi = b;
            end
            POS_HUM_LSB: begin
               crc_acc = crc8_step(crc_acc, b);
               hum_lo = b;
            end
            default: begin
               scaled = (TEMP_GAIN * temp_word) >> SCALE_SHIFT;
               r.temp_milli = temp_type'(scaled - TEMP_BIAS);
               scaled = (HUM_GAIN * {hum_hi, hum_lo}) >> SCALE_SHIFT;
               r.hum_milli = hum_type'(scaled);
               r.temp_crc_ok = temp_pass;
               r.hum_crc_ok = (crc_acc == b);
               r.frame_ok = temp_pass && r.hum_crc_ok;
               pending_readings.push_back(r);
               crc_acc = CRC8_SEED;
            end
         endcase
         frame_pos = (frame_pos == POS_HUM_CRC) ? POS_IDLE : frame_pos + 3'd1;
      end
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      reply_byte_type nxt;
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (reply_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = reply_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.data;
            req_frame_start <= nxt.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      req_taken <= req_valid && req_ready;
      if (reset) begin
         frame_pos = POS_IDLE;
         crc_acc = CRC8_SEED;
         temp_word = '0;
         temp_pass = 1'b0;
         hum_hi = '0;
         hum_lo = '0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Unexpected reading: temp %0d hum %0d", rsp_temperature_milli,
                           rsp_humidity_milli);
               end
            end else begin
               want = pending_readings.pop_front();
               if (rsp_temperature_milli !== want.temp_milli
                   || rsp_humidity_milli !== want.hum_milli
                   || rsp_temperature_crc_ok !== want.temp_crc_ok
                   || rsp_humidity_crc_ok !== want.hum_crc_ok
                   || rsp_frame_ok !== want.frame_ok) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Reading mismatch: expected temp %0d hum %0d crc %b%b ok %b",
                              want.temp_milli, want.hum_milli, want.temp_crc_ok,
                              want.hum_crc_ok, want.frame_ok);
                     $display("                  actual   temp %0d hum %0d crc %b%b ok %b",
                              rsp_temperature_milli, rsp_humidity_milli,
                              rsp_temperature_crc_ok, rsp_humidity_crc_ok, rsp_frame_ok);
                  end
               end
            end
         end
         if (req_valid && req_ready) decode_reply_byte(req_data_byte, req_frame_start);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer in %0d cycles.", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      idle_plan = '{0, 86, 0, 38};
      stall_plan = '{0, 0, 86, 38};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bytes before the first start and after a complete frame must be ignored, and a
      // start in mid-frame drops the partial frame.
      queue_byte(8'hA5, 1'b0);
      queue_byte(8'h5A, 1'b0);
      queue_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 6);
      queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 6);
      queue_frame(16'h6611, 16'h8000, 1'b1, 1'b1, 3);
      queue_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 6);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         recv_stall_pct = stall_plan[p];
         queue_random_traffic(ITEMS_PER_PHASE);
         while (reply_bytes.size() != 0 || req_valid) @(negedge clock);
      end

      while (req_valid || pending_readings.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending_readings.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/thfd_pkg.sv
rtl/thfd_convert.sv
rtl/temp_humidity_frame_decoder.sv
test/tb_temp_humidity_frame_decoder.sv
